### hw/rtl/kcr_pkg.sv
// Keyframe color ramp: shared types, field positions, register indexes and
// the built-in default curve. No dependencies; every other file imports it.
package kcr_pkg;

  localparam int unsigned TICK_W   = 16;
  localparam int unsigned BRIGHT_W = 16;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned WORD_W   = 56;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned IN_W     = 32;

  // Keyframe word layout
  localparam int unsigned TICK_LSB   = 40;
  localparam int unsigned BRIGHT_LSB = 24;
  localparam int unsigned RED_LSB    = 16;
  localparam int unsigned GREEN_LSB  = 8;
  localparam int unsigned BLUE_LSB   = 0;

  // Register indexes on the write port
  localparam logic [IDX_W-1:0] REG_COUNT = 3'd0;
  localparam logic [IDX_W-1:0] REG_WORD0 = 3'd1;

  // Built-in curve
  localparam logic [CNT_W-1:0] DEFAULT_COUNT = 3'd4;
  localparam int unsigned      DEFAULT_KF    = 4;

  // Interpolation lanes: one divider lane per output field
  localparam int unsigned LANES       = 4;
  localparam int unsigned LANE_BRIGHT = 0;
  localparam int unsigned LANE_RED    = 1;
  localparam int unsigned LANE_GREEN  = 2;
  localparam int unsigned LANE_BLUE   = 3;

  localparam int unsigned QUO_W = BRIGHT_W;     // quotient bits, one per divider stage
  localparam int unsigned DSR_W = TICK_W + 1;   // divisor: den or 2*den
  localparam int unsigned DVD_W = DSR_W + QUO_W; // dividend stays below divisor << QUO_W

  typedef logic [WORD_W-1:0] kf_word_t;

  typedef struct packed {
    logic                            valid;
    logic [LANES-1:0][DVD_W-1:0]     dividend;
    logic [LANES-1:0][DSR_W-1:0]     divisor;
  } div_req_t;

  function automatic kf_word_t pack_kf(input logic [TICK_W-1:0] tick,
                                       input logic [BRIGHT_W-1:0] bright,
                                       input logic [CHAN_W-1:0] r,
                                       input logic [CHAN_W-1:0] g,
                                       input logic [CHAN_W-1:0] b);
    return {tick, bright, r, g, b};
  endfunction

  // Default keyframe k; ticks of keyframes 1..3 are passed in by the caller.
  function automatic kf_word_t def_word(input int unsigned k,
                                        input logic [TICK_W-1:0] t_q1,
                                        input logic [TICK_W-1:0] t_half,
                                        input logic [TICK_W-1:0] t_q3);
    kf_word_t w;
    case (k)
      0: w = pack_kf(16'd0, 16'd18022, 8'd255, 8'd170, 8'd120);
      1: w = pack_kf(t_q1, 16'd32768, 8'd135, 8'd206, 8'd235);
      2: w = pack_kf(t_half, 16'd18022, 8'd255, 8'd130, 8'd90);
      3: w = pack_kf(t_q3, 16'd2621, 8'd12, 8'd14, 8'd34);
      default: w = '0;
    endcase
    return w;
  endfunction

  // Field of a keyframe that feeds a given lane, zero-extended to 16 bits
  function automatic logic [BRIGHT_W-1:0] kf_field(input kf_word_t w, input int unsigned lane);
    logic [BRIGHT_W-1:0] f;
    case (lane)
      LANE_BRIGHT: f = w[BRIGHT_LSB +: BRIGHT_W];
      LANE_RED:    f = {8'd0, w[RED_LSB +: CHAN_W]};
      LANE_GREEN:  f = {8'd0, w[GREEN_LSB +: CHAN_W]};
      LANE_BLUE:   f = {8'd0, w[BLUE_LSB +: CHAN_W]};
      default:     f = '0;
    endcase
    return f;
  endfunction

endpackage

### hw/rtl/keyframe_color_ramp_top.sv
// Keyframe color ramp top level: keyframe registers, default-curve select,
// modulo, segment and divider pipelines. Depends on kcr_pkg and all kcr_ modules.
// Pipeline: 3 modulo stages, 4 segment/operand stages and 16 divider stages, one per
// quotient bit, lie between the accepting edge and the edge that takes the result.
// Throughput: one item per cycle, every cycle; busy stays low and results never stall.
// Reset: asynchronous, active low; clears the pipeline valid bits and loads the default curve.
module keyframe_color_ramp_top import kcr_pkg::*; #(
  parameter int unsigned DAY_TICKS     = 24000,
  parameter int unsigned MAX_KEYFRAMES = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item channel
  input  logic                start,
  output logic                busy,
  input  logic [IN_W-1:0]     tick_count_i,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [IDX_W-1:0]    cfg_idx_i,
  input  logic [WORD_W-1:0]   cfg_wdata_i,
  // result strobe and fields
  output logic                valid_o,
  output logic [BRIGHT_W-1:0] brightness_o,
  output logic [CHAN_W-1:0]   red_o,
  output logic [CHAN_W-1:0]   green_o,
  output logic [CHAN_W-1:0]   blue_o
);

  // The table always holds room for the four built-in keyframes
  localparam int unsigned NSLOT = (MAX_KEYFRAMES > DEFAULT_KF) ? MAX_KEYFRAMES : DEFAULT_KF;
  localparam int unsigned NW    = $clog2(NSLOT + 1);
  localparam int unsigned NWORD = 4;  // keyframe words reachable from the write port

  localparam logic [TICK_W-1:0] T_Q1   = TICK_W'(DAY_TICKS / 4);
  localparam logic [TICK_W-1:0] T_HALF = TICK_W'(DAY_TICKS / 2);
  localparam logic [TICK_W-1:0] T_Q3   = TICK_W'((DAY_TICKS * 3) / 4);
  localparam logic [CNT_W:0]    MAX_N  = (CNT_W + 1)'(MAX_KEYFRAMES);

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must write only while the pipeline is empty; the block
  // does not enforce it. The stages read the table combinationally without a shadow copy.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] count_q;
  kf_word_t         kf_q [MAX_KEYFRAMES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= DEFAULT_COUNT;
    end else if (cfg_we_i && (cfg_idx_i == REG_COUNT)) begin
      count_q <= cfg_wdata_i[CNT_W-1:0];
    end
  end

  for (genvar gk = 0; gk < MAX_KEYFRAMES; gk++) begin : g_kf
    if (gk < NWORD) begin : g_wr
      // Word gk resets to the default keyframe and takes writes at its index
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          kf_q[gk] <= def_word(gk, T_Q1, T_HALF, T_Q3);
        end else if (cfg_we_i && (cfg_idx_i == REG_WORD0 + IDX_W'(gk))) begin
          kf_q[gk] <= cfg_wdata_i;
        end
      end
    end else begin : g_fixed
      // Slots past the register list hold zero for good
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          kf_q[gk] <= '0;
        end else begin
          kf_q[gk] <= '0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Effective table: a count of zero swaps in the built-in curve; a count
  // past the slot limit saturates.
  // ---------------------------------------------------------------------------
  kf_word_t      eff_w [NSLOT];
  logic [NW-1:0] eff_n;

  for (genvar gs = 0; gs < NSLOT; gs++) begin : g_eff
    kf_word_t dflt, stored;
    if (gs < DEFAULT_KF) begin : g_dflt
      assign dflt = def_word(gs, T_Q1, T_HALF, T_Q3);
    end else begin : g_nodflt
      assign dflt = '0;
    end
    if (gs < MAX_KEYFRAMES) begin : g_st
      assign stored = kf_q[gs];
    end else begin : g_nost
      assign stored = '0;
    end
    assign eff_w[gs] = (count_q == '0) ? dflt : stored;
  end

  always_comb begin
    if (count_q == '0) begin
      eff_n = NW'(DEFAULT_KF);
    end else if ({1'b0, count_q} > MAX_N) begin
      eff_n = NW'(MAX_KEYFRAMES);
    end else begin
      eff_n = NW'(count_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline: take an item every cycle; the valid bit rides along.
  // ---------------------------------------------------------------------------
  logic                        accept;
  logic                        mod_valid;
  logic [TICK_W-1:0]           mod_tod;
  div_req_t                    div_req;
  logic                        div_valid;
  logic [LANES-1:0][QUO_W-1:0] div_quo;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Reduce the tick count into one day
  kcr_mod #(
    .DAY_TICKS (DAY_TICKS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .tick_i  (tick_count_i),
    .valid_o (mod_valid),
    .tod_o   (mod_tod)
  );

  // Find the segment and build one division per output field
  kcr_seg #(
    .DAY_TICKS (DAY_TICKS),
    .NSLOT     (NSLOT),
    .NW        (NW)
  ) u_seg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mod_valid),
    .tod_i   (mod_tod),
    .n_i     (eff_n),
    .words_i (eff_w),
    .req_o   (div_req)
  );

  // Divide: brightness lane rounds to nearest, color lanes floor
  kcr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (div_req),
    .valid_o (div_valid),
    .quo_o   (div_quo)
  );

  // Results come straight off the last divider stage for one cycle each
  assign valid_o      = div_valid;
  assign brightness_o = div_quo[LANE_BRIGHT];
  assign red_o        = div_quo[LANE_RED][CHAN_W-1:0];
  assign green_o      = div_quo[LANE_GREEN][CHAN_W-1:0];
  assign blue_o       = div_quo[LANE_BLUE][CHAN_W-1:0];

  a_color_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_valid |-> ((div_quo[LANE_RED][QUO_W-1:CHAN_W] == '0) &&
                   (div_quo[LANE_GREEN][QUO_W-1:CHAN_W] == '0) &&
                   (div_quo[LANE_BLUE][QUO_W-1:CHAN_W] == '0)))
    else $error("color quotient exceeds channel width");

endmodule

### hw/rtl/kcr_mod.sv
// Keyframe color ramp: three-stage reduction of the tick count modulo the
// day length by reciprocal multiply and one correction. Depends on kcr_pkg.
module kcr_mod import kcr_pkg::*; #(
  parameter int unsigned DAY_TICKS = 24000
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [IN_W-1:0]   tick_i,
  output logic              valid_o,
  output logic [TICK_W-1:0] tod_o
);

  localparam logic [63:0]       RECIP64 = 64'h1_0000_0000 / 64'(DAY_TICKS);
  localparam logic [31:0]       RECIP   = RECIP64[31:0];
  localparam logic [TICK_W-1:0] DAY16   = TICK_W'(DAY_TICKS);
  localparam logic [TICK_W:0]   DAY17   = (TICK_W + 1)'(DAY_TICKS);

  logic              v1_q, v2_q, v3_q;
  logic [IN_W-1:0]   tick1_q, tick2_q;
  logic [63:0]       prod1_d, prod1_q;
  logic [47:0]       qd_full;
  logic [IN_W-1:0]   qd2_q;
  logic [IN_W-1:0]   r0;
  logic [TICK_W:0]   rmod;
  logic [TICK_W-1:0] tod3_d, tod3_q;

  // Quotient estimate is the true quotient or one less
  assign prod1_d = tick_i * RECIP;
  assign qd_full = prod1_q[63:32] * DAY16;

  // Residue lies below twice the day length: one compare and subtract
  always_comb begin
    r0     = tick2_q - qd2_q;
    rmod   = (r0[TICK_W:0] >= DAY17) ? r0[TICK_W:0] - DAY17 : r0[TICK_W:0];
    tod3_d = rmod[TICK_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tick1_q <= tick_i;
    prod1_q <= prod1_d;
    tick2_q <= tick1_q;
    qd2_q   <= qd_full[IN_W-1:0];
    tod3_q  <= tod3_d;
  end

  assign valid_o = v3_q;
  assign tod_o   = tod3_q;

  a_est_not_above: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (qd2_q <= tick2_q))
    else $error("quotient estimate above true quotient");

  a_tod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (tod3_q < DAY16))
    else $error("reduced tick not below day length");

endmodule

### hw/rtl/kcr_seg.sv
// Keyframe color ramp: segment search, operand fetch, lane products and
// dividend build in four register stages. Depends on kcr_pkg.
module kcr_seg import kcr_pkg::*; #(
  parameter int unsigned DAY_TICKS = 24000,
  parameter int unsigned NSLOT     = 4,
  parameter int unsigned NW        = $clog2(NSLOT + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [TICK_W-1:0] tod_i,
  input  logic [NW-1:0]     n_i,
  input  kf_word_t          words_i [NSLOT],
  output div_req_t          req_o
);

  localparam int unsigned       SW    = $clog2(NSLOT);
  localparam logic [TICK_W-1:0] DAY16 = TICK_W'(DAY_TICKS);

  // Segment bounds follow from the keyframe table alone
  logic [TICK_W-1:0] seg_cur [NSLOT];
  logic [TICK_W-1:0] seg_nxt [NSLOT];
  logic [TICK_W-1:0] seg_end [NSLOT];
  logic [SW-1:0]     seg_ib  [NSLOT];
  logic [NSLOT-1:0]  hit_d;

  for (genvar gi = 0; gi < NSLOT; gi++) begin : g_seg
    logic last;
    assign seg_cur[gi] = words_i[gi][TICK_LSB +: TICK_W];
    if (gi == NSLOT - 1) begin : g_tail
      assign seg_nxt[gi] = DAY16;
    end else begin : g_mid
      assign seg_nxt[gi] = words_i[gi + 1][TICK_LSB +: TICK_W];
    end
    assign last        = (n_i == NW'(gi + 1));
    assign seg_end[gi] = last ? DAY16 : seg_nxt[gi];
    assign seg_ib[gi]  = last ? '0 : SW'(gi + 1);
    assign hit_d[gi]   = (NW'(gi) < n_i) && (tod_i >= seg_cur[gi]) && (tod_i < seg_end[gi]);
  end

  // Stage A: hit flags
  logic              va_q;
  logic [NSLOT-1:0]  hit_q;
  logic [TICK_W-1:0] tod_a_q;

  // Stage B: first hit selects the segment; no hit gives keyframe 0 as is
  logic              vb_q;
  logic [TICK_W-1:0] num_d, num_q, den_d, den_q;
  logic [BRIGHT_W-1:0] a_d [LANES];
  logic [BRIGHT_W-1:0] b_d [LANES];
  logic [BRIGHT_W-1:0] a_q [LANES];
  logic [BRIGHT_W-1:0] b_q [LANES];

  always_comb begin
    logic [SW-1:0] sel, ia, ib;
    logic          found;
    sel   = '0;
    found = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      if (!found && hit_q[i]) begin
        sel   = SW'(i);
        found = 1'b1;
      end
    end
    ia    = found ? sel : '0;
    ib    = found ? seg_ib[sel] : '0;
    num_d = found ? tod_a_q - seg_cur[sel] : '0;
    den_d = found ? seg_end[sel] - seg_cur[sel] : TICK_W'(1);
    for (int l = 0; l < LANES; l++) begin
      a_d[l] = kf_field(words_i[ia], l);
      b_d[l] = kf_field(words_i[ib], l);
    end
  end

  // Stage C: a*den and |b-a|*num per lane
  logic              vc_q;
  logic [TICK_W-1:0] den_c_q;
  logic [2*TICK_W-1:0] pa_d [LANES];
  logic [2*TICK_W-1:0] pd_d [LANES];
  logic [2*TICK_W-1:0] pa_q [LANES];
  logic [2*TICK_W-1:0] pd_q [LANES];
  logic [LANES-1:0]    neg_d, neg_q;

  always_comb begin
    logic [BRIGHT_W-1:0] diff;
    diff = '0;
    for (int l = 0; l < LANES; l++) begin
      neg_d[l] = (b_q[l] < a_q[l]);
      diff     = neg_d[l] ? a_q[l] - b_q[l] : b_q[l] - a_q[l];
      pa_d[l]  = a_q[l] * den_q;
      pd_d[l]  = diff * num_q;
    end
  end

  // Stage D: dividends; brightness rounds via (2*total + den) / (2*den)
  div_req_t                    req_d;
  logic                        req_valid_q;
  logic [LANES-1:0][DVD_W-1:0] req_dvd_q;
  logic [LANES-1:0][DSR_W-1:0] req_dsr_q;

  always_comb begin
    logic [2*TICK_W-1:0] tot;
    tot          = '0;
    req_d.valid  = vc_q;
    for (int l = 0; l < LANES; l++) begin
      tot = neg_q[l] ? pa_q[l] - pd_q[l] : pa_q[l] + pd_q[l];
      if (l == LANE_BRIGHT) begin
        req_d.dividend[l] = {tot, 1'b0} + DVD_W'(den_c_q);
        req_d.divisor[l]  = {den_c_q, 1'b0};
      end else begin
        req_d.dividend[l] = DVD_W'(tot);
        req_d.divisor[l]  = DSR_W'(den_c_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      req_valid_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      req_valid_q <= req_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q   <= hit_d;
    tod_a_q <= tod_i;
    num_q   <= num_d;
    den_q   <= den_d;
    a_q     <= a_d;
    b_q     <= b_d;
    den_c_q <= den_q;
    pa_q    <= pa_d;
    pd_q    <= pd_d;
    neg_q   <= neg_d;
    req_dvd_q <= req_d.dividend;
    req_dsr_q <= req_d.divisor;
  end

  assign req_o = {req_valid_q, req_dvd_q, req_dsr_q};

  a_frac_below_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q |-> (num_q < den_q))
    else $error("segment offset not below segment length");

endmodule

### hw/rtl/kcr_div.sv
// Keyframe color ramp: pipelined restoring divider, one quotient bit per
// stage, all lanes sharing one valid chain. Depends on kcr_pkg.
module kcr_div import kcr_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  div_req_t                    req_i,
  output logic                        valid_o,
  output logic [LANES-1:0][QUO_W-1:0] quo_o
);

  logic                        v_q   [QUO_W];
  logic [LANES-1:0][DVD_W-1:0] rem_q [QUO_W];
  logic [LANES-1:0][DSR_W-1:0] dsr_q [QUO_W];
  logic [LANES-1:0][QUO_W-1:0] quo_q [QUO_W];

  for (genvar gs = 0; gs < QUO_W; gs++) begin : g_stage
    localparam int unsigned SH = QUO_W - 1 - gs;
    logic                        v_in;
    logic [LANES-1:0][DVD_W-1:0] rem_in, rem_d;
    logic [LANES-1:0][DSR_W-1:0] dsr_in;
    logic [LANES-1:0][QUO_W-1:0] quo_in, quo_d;

    if (gs == 0) begin : g_first
      assign v_in   = req_i.valid;
      assign rem_in = req_i.dividend;
      assign dsr_in = req_i.divisor;
      assign quo_in = '0;
    end else begin : g_next
      assign v_in   = v_q[gs - 1];
      assign rem_in = rem_q[gs - 1];
      assign dsr_in = dsr_q[gs - 1];
      assign quo_in = quo_q[gs - 1];
    end

    always_comb begin
      logic [DVD_W-1:0] trial;
      logic             take;
      trial = '0;
      take  = 1'b0;
      for (int l = 0; l < LANES; l++) begin
        trial     = DVD_W'(dsr_in[l]) << SH;
        take      = (rem_in[l] >= trial);
        rem_d[l]  = take ? rem_in[l] - trial : rem_in[l];
        quo_d[l]  = {quo_in[l][QUO_W-2:0], take};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[gs] <= 1'b0;
      end else begin
        v_q[gs] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[gs] <= rem_d;
      dsr_q[gs] <= dsr_in;
      quo_q[gs] <= quo_d;
    end
  end

  assign valid_o = v_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];

  logic rem_ok;
  always_comb begin
    rem_ok = 1'b1;
    for (int l = 0; l < LANES; l++) begin
      if (rem_q[QUO_W-1][l] >= DVD_W'(dsr_q[QUO_W-1][l])) begin
        rem_ok = 1'b0;
      end
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[QUO_W-1] |-> rem_ok)
    else $error("divider remainder not below divisor: quotient overflow");

endmodule

### bench/tb_keyframe_color_ramp_top.sv
// Self-checking bench for keyframe_color_ramp_top: directed and random tick queries
// against a behavioral predictor, with register writes between phases.
// Depends on kcr_pkg and the keyframe_color_ramp_top RTL.
`timescale 1ns / 1ps

module tb_keyframe_color_ramp_top;
  import kcr_pkg::*;

  localparam int unsigned DAY_TICKS     = 24000;
  localparam int unsigned MAX_KEYFRAMES = 4;
  localparam int unsigned PIPE_LATENCY  = 23;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_ITEMS  = 1625;
  // Largest whole number of days that still fits a 32-bit tick with room for one day.
  localparam int unsigned MAX_DAY_MULT  = 178955;
  // First index past the keyframe words; writes there must leave every register alone.
  localparam logic [IDX_W-1:0] REG_PAST_END = REG_WORD0 + 3'd4;

  typedef struct packed {
    logic [BRIGHT_W-1:0] brightness;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
  } shade_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                start        = 1'b0;
  logic                busy;
  logic [IN_W-1:0]     tick_count_i = '0;
  logic                cfg_we_i     = 1'b0;
  logic [IDX_W-1:0]    cfg_idx_i    = '0;
  logic [WORD_W-1:0]   cfg_wdata_i  = '0;
  logic                valid_o;
  logic [BRIGHT_W-1:0] brightness_o;
  logic [CHAN_W-1:0]   red_o;
  logic [CHAN_W-1:0]   green_o;
  logic [CHAN_W-1:0]   blue_o;

  // Shadow copy of the register file, updated as each write lands.
  logic [CNT_W-1:0] kf_count_m;
  kf_word_t         kf_words_m [MAX_KEYFRAMES];

  shade_t      pending_shades [$];
  shade_t      due_shade;
  int unsigned idle_pct;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  keyframe_color_ramp_top #(
    .DAY_TICKS    (DAY_TICKS),
    .MAX_KEYFRAMES(MAX_KEYFRAMES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .tick_count_i(tick_count_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_o     (valid_o),
    .brightness_o(brightness_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Built-in day curve: dawn, noon, dusk, night at quarter-day spacing.
  function automatic kf_word_t stock_keyframe(input int unsigned k);
    logic [TICK_W-1:0] q1;
    logic [TICK_W-1:0] half;
    logic [TICK_W-1:0] q3;
    q1   = TICK_W'(DAY_TICKS / 4);
    half = TICK_W'(DAY_TICKS / 2);
    q3   = TICK_W'((DAY_TICKS * 3) / 4);
    case (k)
      0:       return {16'd0, 16'd18022, 8'd255, 8'd170, 8'd120};
      1:       return {q1, 16'd32768, 8'd135, 8'd206, 8'd235};
      2:       return {half, 16'd18022, 8'd255, 8'd130, 8'd90};
      default: return {q3, 16'd2621, 8'd12, 8'd14, 8'd34};
    endcase
  endfunction

  // Blend from a toward b by num/den exactly; round half up or take the floor.
  function automatic longint unsigned blend(input int unsigned a, input int unsigned b,
                                            input int unsigned num, input int unsigned den,
                                            input bit round_half);
    longint unsigned la;
    longint unsigned lb;
    longint unsigned ln;
    longint unsigned ld;
    longint unsigned total;
    la = a;
    lb = b;
    ln = num;
    ld = den;
    if (lb >= la) total = la * ld + (lb - la) * ln;
    else          total = la * ld - (la - lb) * ln;
    if (round_half) return (2 * total + ld) / (2 * ld);
    return total / ld;
  endfunction

  function automatic shade_t predict_shade(input logic [IN_W-1:0] ticks);
    kf_word_t    w [MAX_KEYFRAMES];
    int unsigned n;
    int unsigned t;
    int unsigned ia;
    int unsigned ib;
    int unsigned num;
    int unsigned den;
    int unsigned cur;
    int unsigned nxt;
    bit          hit;
    shade_t      s;
    n = kf_count_m;
    for (int k = 0; k < MAX_KEYFRAMES; k++) begin
      w[k] = (n == 0) ? stock_keyframe(k) : kf_words_m[k];
    end
    if (n == 0) n = 4;
    else if (n > MAX_KEYFRAMES) n = MAX_KEYFRAMES;
    t   = ticks % DAY_TICKS;
    ia  = 0;
    ib  = 0;
    num = 0;
    den = 1;
    hit = 1'b0;
    // Take the first segment that holds t; the last one wraps to keyframe 0.
    for (int i = 0; i < n; i++) begin
      if (!hit) begin
        cur = w[i][TICK_LSB +: TICK_W];
        if (i + 1 == n) nxt = DAY_TICKS;
        else            nxt = w[i + 1][TICK_LSB +: TICK_W];
        if (t >= cur && t < nxt) begin
          hit = 1'b1;
          ia  = i;
          ib  = (i + 1 == n) ? 0 : i + 1;
          num = t - cur;
          den = nxt - cur;
        end
      end
    end
    s.brightness = BRIGHT_W'(blend(w[ia][BRIGHT_LSB +: BRIGHT_W], w[ib][BRIGHT_LSB +: BRIGHT_W],
                                   num, den, 1'b1));
    s.red   = CHAN_W'(blend(w[ia][RED_LSB +: CHAN_W], w[ib][RED_LSB +: CHAN_W],
                            num, den, 1'b0));
    s.green = CHAN_W'(blend(w[ia][GREEN_LSB +: CHAN_W], w[ib][GREEN_LSB +: CHAN_W],
                            num, den, 1'b0));
    s.blue  = CHAN_W'(blend(w[ia][BLUE_LSB +: CHAN_W], w[ib][BLUE_LSB +: CHAN_W],
                            num, den, 1'b0));
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every strobe must match the oldest pending shade.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (pending_shades.size() == 0) begin
        $error("result with nothing pending: brightness %0d rgb %0d %0d %0d",
               brightness_o, red_o, green_o, blue_o);
        fail_count++;
      end else begin
        due_shade = pending_shades.pop_front();
        if (brightness_o !== due_shade.brightness) begin
          $error("brightness: expected %0d, got %0d", due_shade.brightness, brightness_o);
          fail_count++;
        end
        if (red_o !== due_shade.red) begin
          $error("red: expected %0d, got %0d", due_shade.red, red_o);
          fail_count++;
        end
        if (green_o !== due_shade.green) begin
          $error("green: expected %0d, got %0d", due_shade.green, green_o);
          fail_count++;
        end
        if (blue_o !== due_shade.blue) begin
          $error("blue: expected %0d, got %0d", due_shade.blue, blue_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Offer one tick query, idling first at the current rate; predict on acceptance.
  // Leave start high afterwards so back-to-back items need one assignment per edge.
  task automatic send_tick(input logic [IN_W-1:0] ticks);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    tick_count_i <= ticks;
    do @(posedge clk_i); while (busy);
    pending_shades.push_back(predict_shade(ticks));
  endtask

  // Drop start and hold until every pending shade has come back.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_shades.size() != 0);
  endtask

  // Write one register and mirror it; leave the enable high for a following write.
  task automatic cfg_write(input logic [IDX_W-1:0] idx, input kf_word_t data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == REG_COUNT) kf_count_m = data[CNT_W-1:0];
    else if (idx >= REG_WORD0 && idx < REG_WORD0 + MAX_KEYFRAMES)
      kf_words_m[idx - REG_WORD0] = data;
  endtask

  task automatic cfg_done();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic kf_word_t random_word();
    kf_word_t w;
    w[WORD_W-1:32] = 24'($urandom);
    w[31:0]        = $urandom;
    return w;
  endfunction

  // Field value biased toward zero and full scale.
  function automatic logic [15:0] pick_level(input int unsigned width);
    int unsigned top;
    top = (1 << width) - 1;
    case ($urandom_range(7))
      0:       return '0;
      1:       return 16'(top);
      default: return 16'($urandom_range(top));
    endcase
  endfunction

  // Tick query: raw 32-bit, or anywhere in the day or close to a keyframe
  // and then shifted by a random whole number of days.
  function automatic logic [IN_W-1:0] random_tick();
    int unsigned     base;
    int unsigned     k;
    longint unsigned days;
    longint unsigned sum;
    case ($urandom_range(3))
      0: return $urandom;
      1: base = $urandom_range(DAY_TICKS - 1);
      default: begin
        k    = $urandom_range(MAX_KEYFRAMES - 1);
        base = kf_words_m[k][TICK_LSB +: TICK_W];
        base = (base + 2 * DAY_TICKS - 2 + $urandom_range(4)) % DAY_TICKS;
      end
    endcase
    days = ($urandom_range(3) == 0) ? 0 : $urandom_range(MAX_DAY_MULT);
    sum  = base + days * DAY_TICKS;
    return sum[IN_W-1:0];
  endfunction

  // New curve: mostly sorted keyframes with random colors, some packed tight,
  // some pure noise words; the count covers zero and the saturating values too.
  task automatic randomize_curve();
    logic [TICK_W-1:0] tk [MAX_KEYFRAMES];
    logic [TICK_W-1:0] swap;
    int unsigned       kind;
    int unsigned       base;
    kf_word_t          word;
    kind = $urandom_range(9);
    for (int k = 0; k < MAX_KEYFRAMES; k++) tk[k] = TICK_W'($urandom_range(DAY_TICKS - 1));
    if ($urandom_range(1)) tk[0] = '0;
    for (int i = 0; i < MAX_KEYFRAMES - 1; i++) begin
      for (int j = 0; j < MAX_KEYFRAMES - 1 - i; j++) begin
        if (tk[j] > tk[j + 1]) begin
          swap      = tk[j];
          tk[j]     = tk[j + 1];
          tk[j + 1] = swap;
        end
      end
    end
    if (kind == 8) begin
      // one-tick segments
      base = $urandom_range(DAY_TICKS - MAX_KEYFRAMES);
      for (int k = 0; k < MAX_KEYFRAMES; k++) tk[k] = TICK_W'(base + k);
    end
    word = random_word();
    word[CNT_W-1:0] = (kind < 5) ? DEFAULT_COUNT : CNT_W'($urandom_range(7));
    cfg_write(REG_COUNT, word);
    for (int k = 0; k < MAX_KEYFRAMES; k++) begin
      if (kind == 9) word = random_word();
      else word = pack_kf(tk[k], pick_level(BRIGHT_W), CHAN_W'(pick_level(CHAN_W)),
                          CHAN_W'(pick_level(CHAN_W)), CHAN_W'(pick_level(CHAN_W)));
      cfg_write(REG_WORD0 + IDX_W'(k), word);
    end
    cfg_done();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset curve: keyframe edges, last tick of the day, day wrap and the 32-bit top.
  task automatic test_reset_curve();
    drain_results();
    idle_pct = 0;
    send_tick(32'd0);
    send_tick(32'd5999);
    send_tick(32'd6000);
    send_tick(32'd12000);
    send_tick(32'd18001);
    send_tick(32'd23999);
    send_tick(32'hFFFF_FFFF);
    send_tick(DAY_TICKS * 7 + 3);
  endtask

  // Count of zero picks the built-in curve whatever the words hold;
  // upper write-data bits on the count register must be dropped.
  task automatic test_count_zero();
    kf_word_t w;
    drain_results();
    for (int k = 0; k < MAX_KEYFRAMES; k++) cfg_write(REG_WORD0 + IDX_W'(k), random_word());
    w = random_word();
    w[CNT_W-1:0] = '0;
    cfg_write(REG_COUNT, w);
    cfg_done();
    send_tick(32'd9000);
    send_tick(random_tick());
  endtask

  // First keyframe late in the day: earlier ticks return keyframe 0 as is.
  // Full-scale to zero fields exercise rounding and flooring at the extremes.
  task automatic test_late_first_keyframe();
    drain_results();
    cfg_write(REG_COUNT, 56'd2);
    cfg_write(REG_WORD0, pack_kf(16'd5000, 16'hFFFF, 8'd255, 8'd0, 8'd255));
    cfg_write(REG_WORD0 + 3'd1, pack_kf(16'd15000, 16'd0, 8'd0, 8'd255, 8'd0));
    cfg_done();
    send_tick(32'd100);
    send_tick(32'd4999);
    send_tick(32'd10000);
    send_tick(32'd23999);
  endtask

  // Keyframes out of order: ticks that no segment holds fall back to keyframe 0.
  task automatic test_unsorted_keyframes();
    drain_results();
    cfg_write(REG_COUNT, 56'd3);
    cfg_write(REG_WORD0, pack_kf(16'd8000, 16'd30000, 8'd10, 8'd200, 8'd77));
    cfg_write(REG_WORD0 + 3'd1, pack_kf(16'd3000, 16'd1000, 8'd250, 8'd5, 8'd128));
    cfg_write(REG_WORD0 + 3'd2, pack_kf(16'd16000, 16'd40000, 8'd99, 8'd99, 8'd1));
    cfg_done();
    send_tick(32'd2000);
    send_tick(32'd9000);
    send_tick(32'd20000);
  endtask

  // Keyframe tick past the day length: the segment spans the widest divisor.
  task automatic test_wide_segment();
    drain_results();
    cfg_write(REG_COUNT, 56'd2);
    cfg_write(REG_WORD0, pack_kf(16'd0, 16'd7, 8'd3, 8'd250, 8'd128));
    cfg_write(REG_WORD0 + 3'd1, pack_kf(16'hFFFF, 16'hFFFE, 8'd254, 8'd1, 8'd129));
    cfg_done();
    send_tick(32'd23999);
    send_tick(32'd12345);
  endtask

  // Count above the slot count saturates; a repeated tick leaves an empty
  // segment and the next one is a single tick long.
  task automatic test_saturated_count();
    drain_results();
    cfg_write(REG_COUNT, 56'd7);
    cfg_write(REG_WORD0, pack_kf(16'd0, 16'd100, 8'd0, 8'd0, 8'd0));
    cfg_write(REG_WORD0 + 3'd1, pack_kf(16'd7000, 16'd50000, 8'd255, 8'd255, 8'd255));
    cfg_write(REG_WORD0 + 3'd2, pack_kf(16'd7000, 16'd3, 8'd17, 8'd34, 8'd51));
    cfg_write(REG_WORD0 + 3'd3, pack_kf(16'd7001, 16'd65535, 8'd200, 8'd100, 8'd50));
    cfg_done();
    send_tick(32'd6999);
    send_tick(32'd7000);
    send_tick(32'd7001);
    send_tick(32'd0);
    send_tick(32'hFFFF_FFFF);
  endtask

  // Writes past the last register must change nothing.
  task automatic test_ignored_writes();
    drain_results();
    for (int j = 0; j < 3; j++) cfg_write(REG_PAST_END + IDX_W'(j), random_word());
    cfg_done();
    send_tick(random_tick());
  endtask

  // Random curves in phases, rotating the sender idle rate between none, heavy and light.
  task automatic test_random_curves(input int unsigned total);
    int unsigned sent;
    int unsigned phase;
    int unsigned len;
    sent  = 0;
    phase = 0;
    while (sent < total) begin
      drain_results();
      randomize_curve();
      case (phase % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 59;
        default: idle_pct = 18;
      endcase
      len = $urandom_range(40, 100);
      for (int i = 0; i < len; i++) send_tick(random_tick());
      sent += len;
      phase++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Mirror the reset contents: full count over the built-in curve.
    kf_count_m  = DEFAULT_COUNT;
    for (int k = 0; k < MAX_KEYFRAMES; k++) kf_words_m[k] = stock_keyframe(k);
    idle_pct    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_curve();
    test_count_zero();
    test_late_first_keyframe();
    test_unsorted_keyframes();
    test_wide_segment();
    test_saturated_count();
    test_ignored_writes();
    test_random_curves(RANDOM_ITEMS);

    // Let the pipeline run dry so a stray strobe still gets caught.
    drain_results();
    repeat (PIPE_LATENCY) @(posedge clk_i);
    if (fail_count == 0 && pending_shades.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
